FILE: design/phrq_pkg.sv
// Shared types and codes for the per-hart linked run queues.
// No dependencies; imported by every module of the block.
package phrq_pkg;

    typedef enum logic [1:0] {
        OP_PUSH    = 2'd0,
        OP_POP     = 2'd1,
        OP_REM     = 2'd2,
        OP_REM_ANY = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_IDLE      = 3'd3,
        ST_QUEUED    = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE, S_LOOK, S_DECIDE, S_START, S_WALK, S_WCHK, S_TGT, S_FIX, S_OUT
    } state_t;

    // Classified command passed from the front queue to the sequencer.
    typedef struct packed {
        op_t        func;
        logic [2:0] hart;
        logic [5:0] tid;
        logic       hart_ok;
        logic       tid_ok;
        logic       idle_tid;
    } cmd_t;

    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 24;

endpackage

FILE: design/phrq_front.sv
// Front end: accepts command words, flags range and idle-thread cases,
// and holds them in a two-entry queue. Depends on phrq_pkg.
module phrq_front #(
    parameter int HARTS   = 8,
    parameter int THREADS = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [phrq_pkg::S_DATA_W-1:0]    s_tdata,
    output logic                             q_valid,
    input  logic                             q_pop,
    output phrq_pkg::cmd_t                   q_cmd
);
    import phrq_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    cmd_t       in_cmd;
    logic       push, pop;

    always_comb begin
        in_cmd.func     = op_t'(s_tdata[1:0]);
        in_cmd.hart     = s_tdata[4:2];
        in_cmd.tid      = s_tdata[10:5];
        in_cmd.hart_ok  = 32'(s_tdata[4:2]) < HARTS;
        in_cmd.tid_ok   = 32'(s_tdata[10:5]) < THREADS;
        in_cmd.idle_tid = 32'(s_tdata[10:5]) < HARTS;
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = slot_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (push) slot_reg[wr_ptr_reg] <= in_cmd;
    end

`ifndef SYNTHESIS
    a_no_overfill: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd2) |-> !push) else $error("front queue overfilled");
    a_no_underrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0) |-> !pop) else $error("front queue underrun");
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3) else $error("front queue count out of range");
`endif

endmodule

FILE: design/phrq_back.sv
// Back end: sequencer that carries out push, pop and removals on the
// linked queues, with link and owner memories. Depends on phrq_pkg.
module phrq_back #(
    parameter int HARTS   = 8,
    parameter int THREADS = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             q_valid,
    output logic                             q_pop,
    input  phrq_pkg::cmd_t                   q_cmd,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [phrq_pkg::M_DATA_W-1:0]    m_tdata
);
    import phrq_pkg::*;

    localparam int HIW = (HARTS > 1) ? $clog2(HARTS) : 1;
    localparam int TIW = $clog2(THREADS);
    localparam int CW  = $clog2(THREADS + 1);

    state_t           state_reg, state_next;
    cmd_t             cmd_reg;
    logic [HIW-1:0]   hsel_reg;
    logic [TIW-1:0]   cur_reg, prev_reg;
    logic             at_head_reg;
    status_t          status_reg;
    logic [5:0]       thr_reg;
    logic [2:0]       hout_reg;
    logic             lenz_reg;

    logic [TIW-1:0]   head_reg  [HARTS];
    logic [TIW-1:0]   tail_reg  [HARTS];
    logic [CW-1:0]    count_reg [HARTS];
    logic             mark_reg  [THREADS];

    logic [TIW-1:0]   link_mem  [THREADS];
    logic [HIW-1:0]   owner_mem [THREADS];
    logic [TIW-1:0]   link_rd_reg;
    logic [HIW-1:0]   owner_rd_reg;
    logic [TIW-1:0]   link_raddr;

    logic [15:0]      t_ext, hq_ext, len_ext;
    logic [TIW-1:0]   t_idx, hd, tl;
    logic [HIW-1:0]   hq_idx;
    logic [CW-1:0]    cnt;
    logic             tmark;
    logic [7:0]       own_ext;

    assign t_ext   = {10'd0, cmd_reg.tid};
    assign t_idx   = t_ext[TIW-1:0];
    assign hq_ext  = {13'd0, q_cmd.hart};
    assign hq_idx  = hq_ext[HIW-1:0];
    assign hd      = head_reg[hsel_reg];
    assign tl      = tail_reg[hsel_reg];
    assign cnt     = count_reg[hsel_reg];
    assign tmark   = mark_reg[t_idx];
    assign own_ext = {{(8-HIW){1'b0}}, owner_rd_reg};

    // Link read address follows the step of the walk.
    always_comb begin
        case (state_reg)
            S_WALK:  link_raddr = cur_reg;
            S_TGT:   link_raddr = t_idx;
            default: link_raddr = hd;
        endcase
    end

    always_ff @(posedge aclk) begin
        link_rd_reg  <= link_mem[link_raddr];
        owner_rd_reg <= owner_mem[t_idx];
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_DECIDE && cmd_reg.func == OP_PUSH && cmd_reg.hart_ok &&
            cmd_reg.tid_ok && !cmd_reg.idle_tid && !tmark) begin
            owner_mem[t_idx] <= hsel_reg;
            if (cnt != '0) link_mem[tl] <= t_idx;
        end else if (state_reg == S_FIX && !at_head_reg) begin
            link_mem[prev_reg] <= link_rd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else          state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    state_next = S_LOOK;
                end
            end
            S_LOOK: state_next = S_DECIDE;
            S_DECIDE: begin
                state_next = S_OUT;
                if (cmd_reg.func == OP_REM_ANY) begin
                    if (cmd_reg.tid_ok && tmark) state_next = S_START;
                end else if (cmd_reg.func == OP_REM) begin
                    if (cmd_reg.hart_ok && cmd_reg.tid_ok && tmark &&
                        owner_rd_reg == hsel_reg) state_next = S_START;
                end
            end
            S_START: state_next = (hd == t_idx) ? S_TGT : S_WALK;
            S_WALK:  state_next = S_WCHK;
            S_WCHK:  state_next = (link_rd_reg == t_idx) ? S_TGT : S_WALK;
            S_TGT:   state_next = S_FIX;
            S_FIX:   state_next = S_OUT;
            S_OUT:   if (m_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Control state: counts and queued marks.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < HARTS; i++)   count_reg[i] <= '0;
            for (int i = 0; i < THREADS; i++) mark_reg[i]  <= 1'b0;
        end else if (state_reg == S_DECIDE) begin
            if (cmd_reg.func == OP_PUSH && cmd_reg.hart_ok && cmd_reg.tid_ok &&
                !cmd_reg.idle_tid && !tmark) begin
                count_reg[hsel_reg] <= cnt + 1'b1;
                mark_reg[t_idx]     <= 1'b1;
            end else if (cmd_reg.func == OP_POP && cmd_reg.hart_ok && cnt != '0) begin
                count_reg[hsel_reg] <= cnt - 1'b1;
                mark_reg[hd]        <= 1'b0;
            end
        end else if (state_reg == S_FIX) begin
            count_reg[hsel_reg] <= cnt - 1'b1;
            mark_reg[t_idx]     <= 1'b0;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                cmd_reg    <= q_cmd;
                hsel_reg   <= hq_idx;
                hout_reg   <= q_cmd.hart;
                status_reg <= ST_OK;
                thr_reg    <= '0;
                lenz_reg   <= 1'b0;
            end
            S_DECIDE: begin
                case (cmd_reg.func)
                    OP_PUSH: begin
                        if (!cmd_reg.hart_ok) begin
                            status_reg <= ST_NOT_FOUND;
                            lenz_reg   <= 1'b1;
                        end else if (!cmd_reg.tid_ok) begin
                            status_reg <= ST_NOT_FOUND;
                        end else if (cmd_reg.idle_tid) begin
                            status_reg <= ST_IDLE;
                        end else if (tmark) begin
                            status_reg <= ST_QUEUED;
                        end else begin
                            tail_reg[hsel_reg] <= t_idx;
                            if (cnt == '0) head_reg[hsel_reg] <= t_idx;
                        end
                    end
                    OP_POP: begin
                        if (!cmd_reg.hart_ok) begin
                            status_reg <= ST_NOT_FOUND;
                            lenz_reg   <= 1'b1;
                        end else if (cnt == '0) begin
                            status_reg <= ST_EMPTY;
                        end else begin
                            thr_reg            <= 6'(hd);
                            head_reg[hsel_reg] <= link_rd_reg;
                        end
                    end
                    OP_REM: begin
                        if (!cmd_reg.hart_ok) begin
                            status_reg <= ST_NOT_FOUND;
                            lenz_reg   <= 1'b1;
                        end else if (!(cmd_reg.tid_ok && tmark &&
                                       owner_rd_reg == hsel_reg)) begin
                            status_reg <= ST_NOT_FOUND;
                        end
                    end
                    default: begin
                        if (cmd_reg.tid_ok && tmark) begin
                            hsel_reg <= owner_rd_reg;
                            hout_reg <= own_ext[2:0];
                        end else begin
                            status_reg <= ST_NOT_FOUND;
                            lenz_reg   <= 1'b1;
                        end
                    end
                endcase
            end
            S_START: begin
                at_head_reg <= (hd == t_idx);
                cur_reg     <= hd;
            end
            S_WCHK: begin
                // advance the walk, or hold the predecessor of the target
                if (link_rd_reg == t_idx) prev_reg <= cur_reg;
                else                      cur_reg  <= link_rd_reg;
            end
            S_FIX: begin
                if (at_head_reg) head_reg[hsel_reg] <= link_rd_reg;
                else if (tl == t_idx) tail_reg[hsel_reg] <= prev_reg;
            end
            default: ;
        endcase
    end

    assign len_ext  = {{(16-CW){1'b0}}, (lenz_reg ? {CW{1'b0}} : cnt)};
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {5'd0, len_ext[6:0], hout_reg, thr_reg, status_reg};

`ifndef SYNTHESIS
    a_fix_then_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FIX) |=> (state_reg == S_OUT)) else $error("unlink did not finish");
    a_push_marks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DECIDE && cmd_reg.func == OP_PUSH && cmd_reg.hart_ok &&
         cmd_reg.tid_ok && !cmd_reg.idle_tid && !tmark) |=> mark_reg[t_idx])
        else $error("pushed thread not marked");
    a_walk_marked: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WALK) |-> tmark) else $error("walk for unqueued thread");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(cnt) <= THREADS) else $error("queue count exceeds thread count");
`endif

endmodule

FILE: design/per_hart_linked_run_queues_top.sv
// Channel   | dir | fields (low bit up)                          | handshake
// s_ (cmd)  | in  | tdata: func[1:0] hart[4:2] thread_id[10:5]   | s_tvalid/s_tready
// m_ (res)  | out | tdata: status[2:0] thread_out[8:3]          | m_tvalid/m_tready
//           |     |        hart_out[11:9] queue_length[18:12]    |
// Push and pop pass S_LOOK and S_DECIDE before the output handshake; removals add
// S_START, S_WALK/S_WCHK per link walked (one link-memory read each), S_TGT and S_FIX.
// Reset (aresetn low, synchronous) clears counts and queued marks at once.
// A two-entry command queue accepts words while a result waits, until it is full.
module per_hart_linked_run_queues_top #(
    parameter int HARTS   = 8,
    parameter int THREADS = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [phrq_pkg::S_DATA_W-1:0]   s_tdata,  // func, hart, thread_id
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [phrq_pkg::M_DATA_W-1:0]   m_tdata   // status, thread_out, hart_out, queue_length
);
    import phrq_pkg::*;

    cmd_t q_cmd;
    logic q_valid, q_pop;

    phrq_front #(.HARTS(HARTS), .THREADS(THREADS)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd)
    );

    phrq_back #(.HARTS(HARTS), .THREADS(THREADS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

endmodule
